FILE: rtl/dplt_pkg.sv
// Package for the demand-paging LRU translator: sizes, register indexes,
// payload structs and the internal page-table and victim types. No dependencies.
package dplt_pkg;

    localparam int MAX_PAGES   = 64;
    localparam int MAX_FRAMES  = 16;
    localparam int OFFSET_BITS = 12;

    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int FRAME_W  = $clog2(MAX_FRAMES);
    localparam int VPN_W    = 32 - OFFSET_BITS;
    localparam int STAMP_W  = 32;
    localparam int PCNT_W   = 7;
    localparam int FCNT_W   = 5;
    localparam int PHYS_W   = 16;
    localparam int ADDR_W   = 3;
    // Scan counter width: one extra bit to count past the last page.
    localparam int SCAN_W   = PAGE_W + 1;

    // Register index, taken from paddr[2].
    localparam logic REG_PAGE_COUNT  = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    localparam logic [PCNT_W-1:0] PAGE_COUNT_RST  = PCNT_W'(MAX_PAGES);
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = FCNT_W'(MAX_FRAMES);

    typedef struct packed {
        logic        kind;
        logic [31:0] virt_addr;
    } t_in;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_addr;
        logic              bad_address;
        logic              page_fault;
        logic              replaced;
        logic              write_back;
        logic [31:0]       load_total;
        logic [31:0]       save_total;
        logic [31:0]       replace_total;
    } t_out;

    // One page-table entry held in memory.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] stamp;
    } t_pte;

    // Control of the shared compare unit.
    typedef struct packed {
        logic clear;
        logic cmp;
    } t_scan_ctl;

    // Running best candidate of the LRU scan.
    typedef struct packed {
        logic               found;
        logic [PAGE_W-1:0]  idx;
        logic [FRAME_W-1:0] frame;
    } t_victim;

endpackage

FILE: rtl/demand_paging_lru_translator.sv
// Top level of the demand-paging translator with LRU replacement.
// Holds the sequencer, residency flags, counters and the APB register port.
// Depends on dplt_pkg, dplt_page_ram and dplt_lru_min.
//
// Usage: each input beat on i_in (valid/ready) is a read or write of a
// virtual byte address; each one yields exactly one result beat on o_out
// (valid/ready) with the physical address, the fault flags and the running
// load, save and replace totals. The user writes configuration (page_count at
// 0x0, frame_count at 0x4) via the APB port while the block idles (not enforced).
//
// A bad address goes straight on to emit and the output register. A hit or a
// fault that finds a free frame passes through the decision on the page-table
// read, commit and the output register. A fault with no free frame walks all
// 64 page-table entries through the single memory read port and the shared
// compare unit, then passes through evict, commit and the output register.
// o_ready is high only when idle, so a new beat is taken only after the
// previous one has reached the output register.
//
// The output register decouples the two sides: a new beat is accepted while
// a finished result waits. If the receiver stalls, the next result waits in
// its final state until the output register frees up. Reset (synchronous,
// active low) clears all residency, dirty and frame-use flags, the access
// clock and the totals, and restores page_count = 64 and frame_count = 16.
module demand_paging_lru_translator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  dplt_pkg::t_in               i_in,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output dplt_pkg::t_out              o_out,
    // APB configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dplt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOKUP = 6'b000010,
        S_SCAN   = 6'b000100,
        S_EVICT  = 6'b001000,
        S_COMMIT = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [dplt_pkg::PCNT_W-1:0] r_page_count;
    logic [dplt_pkg::FCNT_W-1:0] r_frame_count;

    // Per-item working registers.
    logic                               r_kind;
    logic [dplt_pkg::PAGE_W-1:0]        r_page;
    logic [dplt_pkg::OFFSET_BITS-1:0]   r_offset;
    logic                               r_bad;
    logic                               r_fault;
    logic                               r_repl;
    logic                               r_wb;
    logic [dplt_pkg::FRAME_W-1:0]       r_frame;

    // Scan sequencer: r_idx issues reads, r_cmp_* follows it in the next cycle.
    logic [dplt_pkg::SCAN_W-1:0]        r_idx;
    logic                               r_cmp_vld;
    logic [dplt_pkg::PAGE_W-1:0]        r_cmp_idx;

    // Residency state and counters.
    logic [dplt_pkg::MAX_PAGES-1:0]     r_loaded;
    logic [dplt_pkg::MAX_PAGES-1:0]     r_dirty;
    logic [dplt_pkg::MAX_FRAMES-1:0]    r_used;
    logic [dplt_pkg::STAMP_W-1:0]       r_clock;
    logic [31:0]                        r_loads;
    logic [31:0]                        r_saves;
    logic [31:0]                        r_repls;

    // Output register.
    logic                               r_out_valid;
    dplt_pkg::t_out                     r_out;

    // Memory and compare unit hookup.
    logic                               ram_we;
    dplt_pkg::t_pte                     ram_wdata;
    logic                               ram_re;
    logic [dplt_pkg::PAGE_W-1:0]        ram_raddr;
    dplt_pkg::t_pte                     ram_rdata;
    dplt_pkg::t_scan_ctl                scan_ctl;
    dplt_pkg::t_victim                  best;

    logic                               in_fire;
    logic                               cfg_wr;
    logic                               out_free;
    logic [dplt_pkg::VPN_W-1:0]         vpn;
    logic [dplt_pkg::PCNT_W-1:0]        pages;
    logic [dplt_pkg::FCNT_W-1:0]        frames;
    logic                               in_bad;
    logic                               free_found;
    logic [dplt_pkg::FRAME_W-1:0]       lowest_free;
    logic                               scan_last;

    assign in_fire  = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    // Registers above the supported range act as the maximum; zero frames
    // acts as one frame, zero pages makes every address bad.
    assign pages  = (r_page_count > dplt_pkg::PCNT_W'(dplt_pkg::MAX_PAGES))
                  ? dplt_pkg::PCNT_W'(dplt_pkg::MAX_PAGES) : r_page_count;
    assign frames = (r_frame_count > dplt_pkg::FCNT_W'(dplt_pkg::MAX_FRAMES))
                  ? dplt_pkg::FCNT_W'(dplt_pkg::MAX_FRAMES)
                  : ((r_frame_count == '0) ? dplt_pkg::FCNT_W'(1) : r_frame_count);

    assign vpn    = i_in.virt_addr[31:dplt_pkg::OFFSET_BITS];
    assign in_bad = (vpn >= dplt_pkg::VPN_W'(pages));

    // Lowest free frame below the configured frame count.
    always_comb begin
        free_found  = 1'b0;
        lowest_free = '0;
        for (int f = dplt_pkg::MAX_FRAMES - 1; f >= 0; f--) begin
            if ((dplt_pkg::FCNT_W'(f) < frames) && !r_used[f]) begin
                free_found  = 1'b1;
                lowest_free = dplt_pkg::FRAME_W'(f);
            end
        end
    end

    assign scan_last = (r_idx == dplt_pkg::SCAN_W'(dplt_pkg::MAX_PAGES));

    // Memory read port: the accessed page on acceptance, the scan index later.
    assign ram_re    = in_fire || ((r_state == S_SCAN) && !scan_last);
    assign ram_raddr = (r_state == S_SCAN) ? r_idx[dplt_pkg::PAGE_W-1:0]
                                           : vpn[dplt_pkg::PAGE_W-1:0];

    assign ram_we    = (r_state == S_COMMIT);
    assign ram_wdata = '{frame: r_frame, stamp: r_clock};

    assign scan_ctl = '{clear: (r_state == S_LOOKUP),
                        cmp:   (r_state == S_SCAN) && r_cmp_vld && r_loaded[r_cmp_idx]};

    dplt_page_ram u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_page),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dplt_lru_min u_lru_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_idx   (r_cmp_idx),
        .i_entry (ram_rdata),
        .o_best  (best)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = in_bad ? S_EMIT : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (r_loaded[r_page] || free_found) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-item payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind   <= i_in.kind;
            r_page   <= vpn[dplt_pkg::PAGE_W-1:0];
            r_offset <= i_in.virt_addr[dplt_pkg::OFFSET_BITS-1:0];
            r_bad    <= in_bad;
            r_fault  <= 1'b0;
            r_repl   <= 1'b0;
            r_wb     <= 1'b0;
        end
        if (r_state == S_LOOKUP) begin
            if (r_loaded[r_page]) begin
                r_frame <= ram_rdata.frame;
            end else begin
                r_fault <= 1'b1;
                r_frame <= lowest_free;
            end
        end
        if (r_state == S_EVICT) begin
            // With no resident page at all, frame 0 is taken without eviction.
            r_frame <= best.found ? best.frame : '0;
            r_repl  <= best.found;
            r_wb    <= best.found && r_dirty[best.idx];
        end
        r_cmp_idx <= r_idx[dplt_pkg::PAGE_W-1:0];
    end

    // Scan counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_idx     <= scan_last ? r_idx : r_idx + dplt_pkg::SCAN_W'(1);
            r_cmp_vld <= !scan_last;
        end else begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end
    end

    // Residency flags, access clock and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_dirty  <= '0;
            r_used   <= '0;
            r_clock  <= '0;
            r_loads  <= '0;
            r_saves  <= '0;
            r_repls  <= '0;
        end else begin
            if ((r_state == S_EVICT) && best.found) begin
                r_loaded[best.idx] <= 1'b0;
                r_dirty[best.idx]  <= 1'b0;
                r_repls            <= r_repls + 32'd1;
                if (r_dirty[best.idx]) begin
                    r_saves <= r_saves + 32'd1;
                end
            end
            if (r_state == S_COMMIT) begin
                r_clock <= r_clock + dplt_pkg::STAMP_W'(1);
                if (r_fault) begin
                    r_used[r_frame]  <= 1'b1;
                    r_loaded[r_page] <= 1'b1;
                    r_dirty[r_page]  <= r_kind;
                    r_loads          <= r_loads + 32'd1;
                end else if (r_kind) begin
                    r_dirty[r_page] <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out.phys_addr     <= r_bad ? '0
                                 : dplt_pkg::PHYS_W'({r_frame, r_offset});
            r_out.bad_address   <= r_bad;
            r_out.page_fault    <= r_fault;
            r_out.replaced      <= r_repl;
            r_out.write_back    <= r_wb;
            r_out.load_total    <= r_loads;
            r_out.save_total    <= r_saves;
            r_out.replace_total <= r_repls;
        end
    end

    // APB register port; the write lands in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count  <= dplt_pkg::PAGE_COUNT_RST;
            r_frame_count <= dplt_pkg::FRAME_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                dplt_pkg::REG_PAGE_COUNT:  r_page_count  <= pwdata[dplt_pkg::PCNT_W-1:0];
                dplt_pkg::REG_FRAME_COUNT: r_frame_count <= pwdata[dplt_pkg::FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dplt_pkg::REG_PAGE_COUNT:  prdata = 32'(r_page_count);
            dplt_pkg::REG_FRAME_COUNT: prdata = 32'(r_frame_count);
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/dplt_page_ram.sv
// Page-table memory: frame number and last-use stamp per virtual page.
// One write port, one registered read port. Uses dplt_pkg.
module dplt_page_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [dplt_pkg::PAGE_W-1:0] i_waddr,
    input  dplt_pkg::t_pte              i_wdata,
    input  logic                        i_re,
    input  logic [dplt_pkg::PAGE_W-1:0] i_raddr,
    output dplt_pkg::t_pte              o_rdata
);

    dplt_pkg::t_pte r_mem [dplt_pkg::MAX_PAGES];
    dplt_pkg::t_pte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dplt_lru_min.sv
// Shared compare unit of the LRU scan: keeps the resident page with the
// smallest stamp seen so far, first index winning on ties. Uses dplt_pkg.
module dplt_lru_min (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dplt_pkg::t_scan_ctl          i_ctl,
    input  logic [dplt_pkg::PAGE_W-1:0]  i_idx,
    input  dplt_pkg::t_pte               i_entry,
    output dplt_pkg::t_victim            o_best
);

    logic                              r_found;
    logic [dplt_pkg::PAGE_W-1:0]       r_idx;
    logic [dplt_pkg::FRAME_W-1:0]      r_frame;
    logic [dplt_pkg::STAMP_W-1:0]      r_stamp;
    logic                              take;

    // Strict less-than keeps the lowest index among equal stamps.
    assign take = i_ctl.cmp && (!r_found || (i_entry.stamp < r_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx   <= i_idx;
            r_frame <= i_entry.frame;
            r_stamp <= i_entry.stamp;
        end
    end

    assign o_best = '{found: r_found, idx: r_idx, frame: r_frame};

endmodule
